// ===== rtl/core/day_night_color_temp_scheduler_assert.svh =====
// Assertion macros shared by the color-temperature scheduler RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef DAY_NIGHT_COLOR_TEMP_SCHEDULER_ASSERT_SVH
`define DAY_NIGHT_COLOR_TEMP_SCHEDULER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DNCTS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in color temperature scheduler");

// The consequent must hold in the cycle after the antecedent.
`define DNCTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in color temperature scheduler");

`endif

// ===== rtl/core/dncts_pkg.sv =====
// Shared widths, codes and types of the day/night color-temperature scheduler.
// Depends on nothing; imported by every module of the block.
package dncts_pkg;

   // Field widths.
   localparam int MINUTE_W = 11;
   localparam int HOUR_W   = 5;
   localparam int FADE_W   = 10;
   localparam int KELVIN_W = 16;
   localparam int MODE_W   = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Signed width used for the window arithmetic around each edge.
   localparam int WIN_W = 13;

   // Mode codes. Codes above automatic also run the schedule.
   localparam logic [MODE_W-1:0] MODE_DAY   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_NIGHT = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FLAT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_OFF   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_AUTO  = 3'd4;

   // Register indexes of the write port.
   localparam logic [CSR_IDX_W-1:0] REG_MODE_SELECT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DAY_HOUR     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_NIGHT_HOUR   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FADE_MINUTES = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DAY_KELVIN   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_NIGHT_KELVIN = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FLAT_KELVIN  = 3'd6;

   // Status of the blend unit as seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } blend_stat_type;

endpackage

// ===== rtl/core/dncts_blend.sv =====
// Serial crossfade unit: shift-add product of the two weighted ends, then a
// restoring divide one quotient bit per cycle. Depends on dncts_pkg.
`include "day_night_color_temp_scheduler_assert.svh"

module dncts_blend
   import dncts_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [KELVIN_W-1:0] from_kelvin,
   input  logic [KELVIN_W-1:0] to_kelvin,
   input  logic [FADE_W-1:0]   num,
   input  logic [FADE_W-1:0]   fade,
   output logic [KELVIN_W-1:0] quotient,
   output blend_stat_type      stat
);

   localparam int ACC_W = KELVIN_W + FADE_W;       // weighted sum width
   localparam int NUM_W = ACC_W + 1;               // doubled sum plus fade
   localparam int DIV_W = FADE_W + 1;              // divisor is twice fade
   localparam int CNT_W = $clog2(KELVIN_W);
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(FADE_W - 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(KELVIN_W - 1);

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_MUL  = 2'd1;
   localparam logic [1:0] B_PREP = 2'd2;
   localparam logic [1:0] B_DIV  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                done_ff, done_in;
   logic [KELVIN_W-1:0] from_ff, from_in;
   logic [KELVIN_W-1:0] to_ff, to_in;
   logic [FADE_W-1:0]   wfrom_ff, wfrom_in;   // weight of from: fade - num
   logic [FADE_W-1:0]   wto_ff, wto_in;       // weight of to: num
   logic [FADE_W-1:0]   fade_ff, fade_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [DIV_W-1:0]    rem_ff, rem_in;
   logic [KELVIN_W-1:0] quo_ff, quo_in;

   logic [KELVIN_W:0]   pp;
   logic [NUM_W-1:0]    dividend;
   logic [DIV_W:0]      trial;
   logic [DIV_W:0]      divisor;
   logic                ge;

   // One partial product per cycle, weight bits taken MSB first.
   assign pp = ({1'b0, wfrom_ff[FADE_W-1] ? from_ff : {KELVIN_W{1'b0}}})
             + ({1'b0, wto_ff[FADE_W-1] ? to_ff : {KELVIN_W{1'b0}}});

   // Dividend 2*acc + fade and the restoring divide step.
   assign dividend = {acc_ff, 1'b0} + NUM_W'(fade_ff);
   assign divisor  = {1'b0, fade_ff, 1'b0};
   assign trial    = {rem_ff, quo_ff[KELVIN_W-1]};
   assign ge       = (trial >= divisor);

   // Sequencing of the multiply and divide phases.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      from_in  = from_ff;
      to_in    = to_ff;
      wfrom_in = wfrom_ff;
      wto_in   = wto_ff;
      fade_in  = fade_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (start) begin
               from_in  = from_kelvin;
               to_in    = to_kelvin;
               wfrom_in = fade - num;
               wto_in   = num;
               fade_in  = fade;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = B_MUL;
            end
         end
         B_MUL: begin
            acc_in   = {acc_ff[ACC_W-2:0], 1'b0} + ACC_W'(pp);
            wfrom_in = {wfrom_ff[FADE_W-2:0], 1'b0};
            wto_in   = {wto_ff[FADE_W-2:0], 1'b0};
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               state_in = B_PREP;
            end
         end
         B_PREP: begin
            // The high part is below the divisor since the quotient fits 16 bits.
            rem_in   = dividend[NUM_W-1:KELVIN_W];
            quo_in   = dividend[KELVIN_W-1:0];
            cnt_in   = '0;
            state_in = B_DIV;
         end
         B_DIV: begin
            rem_in = ge ? DIV_W'(trial - divisor) : trial[DIV_W-1:0];
            quo_in = {quo_ff[KELVIN_W-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               done_in  = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      from_ff  <= from_in;
      to_ff    <= to_in;
      wfrom_ff <= wfrom_in;
      wto_ff   <= wto_in;
      fade_ff  <= fade_in;
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = (state_ff != B_IDLE);
   assign stat.done = done_ff;

   // A start only arrives while the unit is free.
   `DNCTS_ASSERT_SAME(a_start_idle, clock, reset, start, state_ff == B_IDLE)
   // The divide always follows directly on the preparation step.
   `DNCTS_ASSERT_NEXT(a_prep_div, clock, reset, state_ff == B_PREP, state_ff == B_DIV)
   // The partial remainder never reaches the divisor.
   `DNCTS_ASSERT_SAME(a_rem_bound, clock, reset, state_ff == B_DIV,
                      {1'b0, rem_ff} < {1'b0, fade_ff, 1'b0})

endmodule

// ===== rtl/core/day_night_color_temp_scheduler.sv =====
// Top level of the day/night color-temperature scheduler: registers, window
// decode, result register. Depends on dncts_pkg and dncts_blend.
//
//   channel | ports                                         | direction
//   req     | req_valid, req_ready, req_minute_of_day       | in
//   rsp     | rsp_valid, rsp_ready, rsp_target_kelvin,      | out
//           | rsp_is_warm, rsp_target_changed               |
//   csr     | csr_wr_en, csr_index, csr_wdata               | in
//
// Fixed modes and the flat parts of the schedule go from the transfer through
// the setup state into the result register. Inside a crossfade window the
// blend unit runs in between: ten shift-add steps, one preparation step and
// sixteen divide steps, plus the handoffs around it. One item is in work at a
// time; the next one is taken only after the previous result has been passed
// from the result register to the outputs in the final state.
// Reset is synchronous and restores the register defaults and a zero last target.
// A stalled result register holds the finished item in the final state.
`include "day_night_color_temp_scheduler_assert.svh"

module day_night_color_temp_scheduler
   import dncts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [MINUTE_W-1:0]   req_minute_of_day,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [KELVIN_W-1:0]   rsp_target_kelvin,
   output logic                  rsp_is_warm,
   output logic                  rsp_target_changed,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SETUP = 2'd1;
   localparam logic [1:0] ST_BLEND = 2'd2;
   localparam logic [1:0] ST_FIN   = 2'd3;

   logic [MODE_W-1:0]   mode_ff;
   logic [HOUR_W-1:0]   day_hour_ff, night_hour_ff;
   logic [FADE_W-1:0]   fade_ff;
   logic [KELVIN_W-1:0] day_k_ff, night_k_ff, flat_k_ff;

   logic [1:0]          state_ff, state_in;
   logic [MINUTE_W-1:0] minute_ff, minute_in;
   logic [KELVIN_W-1:0] result_ff, result_in;
   logic [KELVIN_W-1:0] last_ff, last_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [KELVIN_W-1:0] rsp_target_ff, rsp_target_in;
   logic                rsp_warm_ff, rsp_warm_in;
   logic                rsp_changed_ff, rsp_changed_in;

   logic                is_auto;
   logic signed [WIN_W-1:0] m_s, dawn_s, dusk_s, half_s;
   logic signed [WIN_W-1:0] dawn_lo, dawn_hi, dusk_lo, dusk_hi;
   logic [WIN_W-1:0]    dawn_off, dusk_off;
   logic                in_dawn, in_dusk, fade_on;
   logic                blend_start;
   logic [KELVIN_W-1:0] blend_from, blend_to, blend_q;
   logic [FADE_W-1:0]   blend_num;
   logic [KELVIN_W-1:0] plain_target;
   logic                out_free;
   blend_stat_type      blend_stat;

   // Configuration writes; an index past the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_AUTO;
         day_hour_ff   <= HOUR_W'(7);
         night_hour_ff <= HOUR_W'(20);
         fade_ff       <= FADE_W'(30);
         day_k_ff      <= KELVIN_W'(6500);
         night_k_ff    <= KELVIN_W'(3500);
         flat_k_ff     <= KELVIN_W'(4500);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_MODE_SELECT:  mode_ff       <= csr_wdata[MODE_W-1:0];
            REG_DAY_HOUR:     day_hour_ff   <= csr_wdata[HOUR_W-1:0];
            REG_NIGHT_HOUR:   night_hour_ff <= csr_wdata[HOUR_W-1:0];
            REG_FADE_MINUTES: fade_ff       <= csr_wdata[FADE_W-1:0];
            REG_DAY_KELVIN:   day_k_ff      <= csr_wdata;
            REG_NIGHT_KELVIN: night_k_ff    <= csr_wdata;
            REG_FLAT_KELVIN:  flat_k_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Edge minutes are hour times sixty, written as 64h - 4h.
   assign is_auto = (mode_ff >= MODE_AUTO);
   assign m_s     = signed'(WIN_W'(minute_ff));
   assign dawn_s  = signed'((WIN_W'(day_hour_ff) << 6) - (WIN_W'(day_hour_ff) << 2));
   assign dusk_s  = signed'((WIN_W'(night_hour_ff) << 6) - (WIN_W'(night_hour_ff) << 2));
   assign half_s  = signed'(WIN_W'(fade_ff >> 1));
   assign dawn_lo = dawn_s - half_s;
   assign dawn_hi = dawn_s + half_s;
   assign dusk_lo = dusk_s - half_s;
   assign dusk_hi = dusk_s + half_s;
   assign fade_on = (fade_ff != '0);
   assign in_dawn = fade_on && (m_s >= dawn_lo) && (m_s < dawn_hi);
   assign in_dusk = fade_on && (m_s >= dusk_lo) && (m_s < dusk_hi);
   assign dawn_off = WIN_W'(m_s - dawn_lo);
   assign dusk_off = WIN_W'(m_s - dusk_lo);

   // The dawn window wins where the two overlap.
   assign blend_from = in_dawn ? night_k_ff : day_k_ff;
   assign blend_to   = in_dawn ? day_k_ff : night_k_ff;
   assign blend_num  = in_dawn ? dawn_off[FADE_W-1:0] : dusk_off[FADE_W-1:0];
   assign blend_start = (state_ff == ST_SETUP) && is_auto && (in_dawn || in_dusk);

   // Target outside the crossfade: fixed modes or the hard step.
   always_comb begin
      priority if (mode_ff == MODE_DAY) begin
         plain_target = day_k_ff;
      end else if (mode_ff == MODE_NIGHT) begin
         plain_target = night_k_ff;
      end else if (mode_ff == MODE_FLAT) begin
         plain_target = flat_k_ff;
      end else if (mode_ff == MODE_OFF) begin
         plain_target = '0;
      end else if ((m_s >= dawn_s) && (m_s < dusk_s)) begin
         plain_target = day_k_ff;
      end else begin
         plain_target = night_k_ff;
      end
   end

   dncts_blend u_blend (
      .clock       (clock),
      .reset       (reset),
      .start       (blend_start),
      .from_kelvin (blend_from),
      .to_kelvin   (blend_to),
      .num         (blend_num),
      .fade        (fade_ff),
      .quotient    (blend_q),
      .stat        (blend_stat)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // Item sequencer and result register.
   always_comb begin
      state_in       = state_ff;
      minute_in      = minute_ff;
      result_in      = result_ff;
      last_in        = last_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_target_in  = rsp_target_ff;
      rsp_warm_in    = rsp_warm_ff;
      rsp_changed_in = rsp_changed_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               minute_in = req_minute_of_day;
               state_in  = ST_SETUP;
            end
         end
         ST_SETUP: begin
            result_in = plain_target;
            state_in  = blend_start ? ST_BLEND : ST_FIN;
         end
         ST_BLEND: begin
            if (blend_stat.done) begin
               result_in = blend_q;
               state_in  = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_target_in  = result_ff;
               rsp_warm_in    = is_auto ? (result_ff < day_k_ff)
                                        : ((mode_ff == MODE_NIGHT) || (mode_ff == MODE_FLAT));
               rsp_changed_in = (result_ff != last_ff);
               last_in        = result_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         last_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      minute_ff      <= minute_in;
      result_ff      <= result_in;
      rsp_target_ff  <= rsp_target_in;
      rsp_warm_ff    <= rsp_warm_in;
      rsp_changed_ff <= rsp_changed_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_target_kelvin  = rsp_target_ff;
   assign rsp_is_warm        = rsp_warm_ff;
   assign rsp_target_changed = rsp_changed_ff;

   // A transfer on the request side always starts the window decode.
   `DNCTS_ASSERT_NEXT(a_req_setup, clock, reset, req_valid && req_ready,
                      state_ff == ST_SETUP)
   // The blend unit only finishes while the sequencer waits for it.
   `DNCTS_ASSERT_SAME(a_done_wait, clock, reset, blend_stat.done, state_ff == ST_BLEND)
   // The blend unit is free whenever a new item may be taken.
   `DNCTS_ASSERT_SAME(a_idle_free, clock, reset, state_ff == ST_IDLE, !blend_stat.busy)
   // A shown result is always the one recorded as last target.
   `DNCTS_ASSERT_SAME(a_last_match, clock, reset, rsp_valid_ff,
                      last_ff == rsp_target_ff)

endmodule

// ===== dv/testbench.sv =====
// Self-checking bench for day_night_color_temp_scheduler: directed plan, then random schedules.
// Results are predicted from its own register copy or typed in the plan, and compared in order.
// Depends on dncts_pkg and the scheduler RTL only.
module testbench
   import dncts_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MINUTES_PER_HOUR = 60;
   localparam int SETTLE_CYCLES    = 4;
   localparam int DRAIN_CYCLES     = 40;
   localparam int HOLD_CYCLES      = 300;
   localparam int LIMIT_CYCLES     = 600000;
   localparam int SEGMENTS         = 6;
   localparam int SEG_ITEMS        = 97;
   localparam int REPORT_LIMIT     = 10;

   // Codes the package leaves unnamed.
   localparam logic [MODE_W-1:0]    MODE_SPARE = 3'd7;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   typedef struct packed {
      logic [KELVIN_W-1:0] kelvin;
      logic                warm;
      logic                changed;
   } sched_result_type;

   // One step of the directed plan: a register write or a minute transfer.
   typedef struct {
      bit                    is_write;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] wdata;
      logic [MINUTE_W-1:0]   minute;
      bit                    typed;
      sched_result_type      want;
   } plan_row_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [MINUTE_W-1:0]   req_minute_of_day = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [KELVIN_W-1:0]   rsp_target_kelvin;
   logic                  rsp_is_warm;
   logic                  rsp_target_changed;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow copy of the scheduler registers and its last emitted target.
   logic [MODE_W-1:0]   cfg_mode     = MODE_AUTO;
   logic [HOUR_W-1:0]   cfg_day_hour = 5'd7;
   logic [HOUR_W-1:0]   cfg_night_hour = 5'd20;
   logic [FADE_W-1:0]   cfg_fade     = 10'd30;
   logic [KELVIN_W-1:0] cfg_day_k    = 16'd6500;
   logic [KELVIN_W-1:0] cfg_night_k  = 16'd3500;
   logic [KELVIN_W-1:0] cfg_flat_k   = 16'd4500;
   logic [KELVIN_W-1:0] last_kelvin  = '0;

   sched_result_type pending_results[$];
   plan_row_type     plan[$];
   int            fault_count = 0;
   int            cycle_count = 0;
   int            req_idle_pct = 0;
   int            rsp_stall_pct = 0;
   logic          hold_rsp = 1'b0;

   day_night_color_temp_scheduler dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_minute_of_day  (req_minute_of_day),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_target_kelvin  (rsp_target_kelvin),
      .rsp_is_warm        (rsp_is_warm),
      .rsp_target_changed (rsp_target_changed),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Linear blend between two temperatures, rounded half up.
   function automatic logic [KELVIN_W-1:0] crossfade_kelvin(input longint unsigned from_k,
                                                            input longint unsigned to_k,
                                                            input longint unsigned pos,
                                                            input longint unsigned span);
      longint unsigned acc;
      acc = from_k * (span - pos) + to_k * pos;
      return KELVIN_W'((2 * acc + span) / (2 * span));
   endfunction

   // Expected result for one minute under the current registers; advances the last target.
   function automatic sched_result_type predict_schedule(input logic [MINUTE_W-1:0] minute);
      sched_result_type    r;
      int                  m;
      int                  dawn;
      int                  dusk;
      int                  fade;
      int                  half;
      logic [KELVIN_W-1:0] t;
      logic                warm;
      m    = int'(minute);
      dawn = int'(cfg_day_hour) * MINUTES_PER_HOUR;
      dusk = int'(cfg_night_hour) * MINUTES_PER_HOUR;
      fade = int'(cfg_fade);
      half = fade / 2;
      case (cfg_mode)
         MODE_DAY: begin
            t = cfg_day_k;
            warm = 1'b0;
         end
         MODE_NIGHT: begin
            t = cfg_night_k;
            warm = 1'b1;
         end
         MODE_FLAT: begin
            t = cfg_flat_k;
            warm = 1'b1;
         end
         MODE_OFF: begin
            t = '0;
            warm = 1'b0;
         end
         default: begin
            // The dawn window is tested first, so it wins where the windows overlap.
            if (fade > 0 && m >= dawn - half && m < dawn + half)
               t = crossfade_kelvin(cfg_night_k, cfg_day_k, m - (dawn - half), fade);
            else if (fade > 0 && m >= dusk - half && m < dusk + half)
               t = crossfade_kelvin(cfg_day_k, cfg_night_k, m - (dusk - half), fade);
            else if (m >= dawn && m < dusk)
               t = cfg_day_k;
            else
               t = cfg_night_k;
            warm = (t < cfg_day_k);
         end
      endcase
      r.kelvin  = t;
      r.warm    = warm;
      r.changed = (t != last_kelvin);
      last_kelvin = t;
      return r;
   endfunction

   function automatic plan_row_type plan_write(input logic [CSR_IDX_W-1:0] idx,
                                               input logic [CSR_DATA_W-1:0] data);
      plan_row_type row;
      row = '{1'b1, idx, data, '0, 1'b0, '0};
      return row;
   endfunction

   function automatic plan_row_type plan_item(input logic [MINUTE_W-1:0] minute);
      plan_row_type row;
      row = '{1'b0, '0, '0, minute, 1'b0, '0};
      return row;
   endfunction

   function automatic plan_row_type plan_known(input logic [MINUTE_W-1:0] minute,
                                               input logic [KELVIN_W-1:0] kelvin,
                                               input logic warm, input logic changed);
      plan_row_type row;
      row = '{1'b0, '0, '0, minute, 1'b1, '{kelvin, warm, changed}};
      return row;
   endfunction

   // Drops valid and waits until every expected result has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write, issued only while the scheduler is idle.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         REG_MODE_SELECT:  cfg_mode       = data[MODE_W-1:0];
         REG_DAY_HOUR:     cfg_day_hour   = data[HOUR_W-1:0];
         REG_NIGHT_HOUR:   cfg_night_hour = data[HOUR_W-1:0];
         REG_FADE_MINUTES: cfg_fade       = data[FADE_W-1:0];
         REG_DAY_KELVIN:   cfg_day_k      = data;
         REG_NIGHT_KELVIN: cfg_night_k    = data;
         REG_FLAT_KELVIN:  cfg_flat_k     = data;
         default: ;
      endcase
   endtask

   // Offers one minute and records its expected result at the transfer.
   task automatic send_minute(input logic [MINUTE_W-1:0] minute, input bit typed,
                              input sched_result_type typed_result);
      sched_result_type predicted;
      req_valid <= 1'b1;
      req_minute_of_day <= minute;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = predict_schedule(minute);
      pending_results.push_back(typed ? typed_result : predicted);
   endtask

   // Result side: check each transfer against the oldest expectation, then pick ready.
   always @(posedge clock) begin
      sched_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("unexpected result at cycle %0d: kelvin %0d warm %0b changed %0b",
                           cycle_count, rsp_target_kelvin, rsp_is_warm, rsp_target_changed);
            end else begin
               want = pending_results.pop_front();
               if (rsp_target_kelvin !== want.kelvin || rsp_is_warm !== want.warm ||
                   rsp_target_changed !== want.changed) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT)
                     $display({"mismatch at cycle %0d: expected kelvin %0d warm %0b ",
                               "changed %0b, got kelvin %0d warm %0b changed %0b"},
                              cycle_count, want.kelvin, want.warm, want.changed,
                              rsp_target_kelvin, rsp_is_warm, rsp_target_changed);
               end
            end
         end
         rsp_ready <= !hold_rsp && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAIL");
         $finish;
      end
   end

   // Stimulus: reset, directed plan, then three idling phases of random schedules.
   initial begin
      int                  sel;
      int                  edge_min;
      int                  half;
      int                  m;
      int                  gap;
      logic [MINUTE_W-1:0] prev_minute;

      prev_minute = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed plan under the reset defaults first, then modes, odd codes and extremes.
      plan = '{
         plan_known(11'd0, 16'd3500, 1'b1, 1'b1),      // first transfer after reset
         plan_known(11'd0, 16'd3500, 1'b1, 1'b0),
         plan_known(11'd405, 16'd3500, 1'b1, 1'b0),    // dawn window opens at night value
         plan_item(11'd420),
         plan_item(11'd434),
         plan_known(11'd435, 16'd6500, 1'b0, 1'b1),
         plan_item(11'd1200),
         plan_known(11'd1215, 16'd3500, 1'b1, 1'b1),
         plan_known(11'd2047, 16'd3500, 1'b1, 1'b0),   // minute past the end of the day
         plan_write(REG_MODE_SELECT, 16'(MODE_DAY)),
         plan_known(11'd2047, 16'd6500, 1'b0, 1'b1),
         plan_write(REG_MODE_SELECT, 16'(MODE_NIGHT)),
         plan_known(11'd0, 16'd3500, 1'b1, 1'b1),
         plan_write(REG_MODE_SELECT, 16'(MODE_FLAT)),
         plan_known(11'd700, 16'd4500, 1'b1, 1'b1),
         plan_write(REG_MODE_SELECT, 16'(MODE_OFF)),
         plan_known(11'd700, 16'd0, 1'b0, 1'b1),
         plan_known(11'd1439, 16'd0, 1'b0, 1'b0),
         plan_write(REG_MODE_SELECT, 16'(MODE_SPARE)), // unused code runs the schedule
         plan_known(11'd600, 16'd6500, 1'b0, 1'b1),
         plan_write(REG_UNUSED, 16'hFFFF),             // write beyond the list is dropped
         plan_known(11'd600, 16'd6500, 1'b0, 1'b0),
         // A wide fade with extreme temperatures; windows run past both ends of the day.
         plan_write(REG_FADE_MINUTES, 16'd720),
         plan_write(REG_DAY_HOUR, 16'd0),
         plan_write(REG_NIGHT_HOUR, 16'd23),
         plan_write(REG_DAY_KELVIN, 16'hFFFF),
         plan_write(REG_NIGHT_KELVIN, 16'd0),
         plan_item(11'd0),
         plan_item(11'd1439),
         plan_item(11'd2047),
         // Overlapping windows: dawn takes precedence.
         plan_write(REG_DAY_HOUR, 16'd12),
         plan_write(REG_NIGHT_HOUR, 16'd13),
         plan_item(11'd500),
         // Hard step with the day hour after the night hour.
         plan_write(REG_FADE_MINUTES, 16'd0),
         plan_write(REG_DAY_HOUR, 16'd20),
         plan_write(REG_NIGHT_HOUR, 16'd7),
         plan_write(REG_DAY_KELVIN, 16'd40000),
         plan_write(REG_NIGHT_KELVIN, 16'd1000),
         plan_item(11'd1300),
         plan_item(11'd600),
         // Hours beyond the day and the largest fade the register holds.
         plan_write(REG_DAY_HOUR, 16'd31),
         plan_write(REG_NIGHT_HOUR, 16'd31),
         plan_write(REG_FADE_MINUTES, 16'd1023),
         plan_item(11'd1900),
         plan_write(REG_FLAT_KELVIN, 16'd0),
         plan_write(REG_MODE_SELECT, 16'(MODE_FLAT)),
         plan_item(11'd0)
      };
      foreach (plan[i]) begin
         if (plan[i].is_write)
            write_reg(plan[i].reg_idx, plan[i].wdata);
         else
            send_minute(plan[i].minute, plan[i].typed, plan[i].want);
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct = 36;
               rsp_stall_pct = 78;
            end
            1: begin
               req_idle_pct = 78;
               rsp_stall_pct = 36;
            end
            default: begin
               req_idle_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         for (int seg = 0; seg < SEGMENTS; seg++) begin
            // New schedule, mostly automatic and mostly inside the documented ranges.
            sel = $urandom_range(99);
            write_reg(REG_MODE_SELECT, (sel < 60) ? 16'(MODE_AUTO) : 16'($urandom_range(7)));
            write_reg(REG_DAY_HOUR,
                      ($urandom_range(99) < 85) ? 16'($urandom_range(23)) : 16'($urandom_range(31)));
            write_reg(REG_NIGHT_HOUR,
                      ($urandom_range(99) < 85) ? 16'($urandom_range(23)) : 16'($urandom_range(31)));
            sel = $urandom_range(99);
            if (sel < 15)      write_reg(REG_FADE_MINUTES, 16'd0);
            else if (sel < 25) write_reg(REG_FADE_MINUTES, 16'd720);
            else if (sel < 32) write_reg(REG_FADE_MINUTES, 16'($urandom_range(1023)));
            else if (sel < 37) write_reg(REG_FADE_MINUTES, 16'd1);
            else               write_reg(REG_FADE_MINUTES, 16'($urandom_range(1, 240)));
            for (int k = 0; k < 3; k++) begin
               sel = $urandom_range(99);
               write_reg(REG_DAY_KELVIN + CSR_IDX_W'(k),
                         (sel < 80) ? 16'($urandom_range(1000, 40000)) :
                         (sel < 90) ? 16'($urandom_range(65535)) :
                         (sel < 95) ? 16'd0 : 16'hFFFF);
            end

            // Long receiver hold-off while the sender keeps offering items.
            if (phase == 0 && seg == 1) begin
               fork
                  begin
                     hold_rsp <= 1'b1;
                     repeat (HOLD_CYCLES) @(posedge clock);
                     hold_rsp <= 1'b0;
                  end
               join_none
            end

            for (int n = 0; n < SEG_ITEMS; n++) begin
               // Sender pause until the scheduler has drained.
               if (seg == 3 && n == SEG_ITEMS / 2)
                  wait_idle();
               sel = $urandom_range(99);
               half = int'(cfg_fade) / 2;
               if (sel < 10) begin
                  m = int'(prev_minute);
               end else if (sel < 55) begin
                  edge_min = ($urandom_range(1) ? int'(cfg_day_hour) : int'(cfg_night_hour))
                             * MINUTES_PER_HOUR;
                  m = edge_min - half - 3 + int'($urandom_range(2 * half + 6));
                  if (m < 0) m = 0;
                  if (m > 2047) m = 2047;
               end else if (sel < 88) begin
                  m = $urandom_range(1439);
               end else begin
                  m = $urandom_range(2047);
               end
               prev_minute = MINUTE_W'(m);
               send_minute(prev_minute, 1'b0, '0);
               gap = ($urandom_range(99) < req_idle_pct) ? $urandom_range(1, 6) : 0;
               if (gap > 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
